// File: rtl/core/prt_pkg.sv
// Package with the sequencer states, status codes and field widths of the reassembly tracker.
`default_nettype none
package prt_pkg;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_HCHK,
		ST_HRD,
		ST_HOFF,
		ST_HFIN,
		ST_VCHK,
		ST_VRD,
		ST_CLR
	} state_t;

	typedef enum logic [3:0] {
		STS_ACCEPTED     = 4'd0,
		STS_TOO_MANY     = 4'd1,
		STS_TOTAL_DIFF   = 4'd2,
		STS_WRONG_BLOCK  = 4'd3,
		STS_BLOCK_DONE   = 4'd4,
		STS_DUPLICATE    = 4'd5,
		STS_LAST_FIRST   = 4'd6,
		STS_PTOT_DIFF    = 4'd7,
		STS_CRC_DIFF     = 4'd8,
		STS_OVERSIZE     = 4'd9,
		STS_OVERFLOW     = 4'd10,
		STS_INDEX_RANGE  = 4'd11,
		STS_VERDICT_PASS = 4'd12,
		STS_VERDICT_FAIL = 4'd13,
		STS_NO_PENDING   = 4'd14,
		STS_AWAITING     = 4'd15
	} status_t;

	localparam int unsigned IN_DATA_W  = 120;
	localparam int unsigned OUT_DATA_W = 96;
	localparam int unsigned SIZE_W     = 16;
	localparam int unsigned LEN_W      = 24;
	localparam int unsigned CRC_W      = 32;
	localparam int unsigned PROD_W     = 32;
	localparam int unsigned INDEX_W    = 10;

endpackage
`default_nettype wire

// File: rtl/core/block_packet_reassembly_tracker_unit.sv
// Top level of the packet reassembly tracker: sequencer, state registers and bitmaps.
//
//  Channel | Dir | Beat contents
//  s_*     | in  | tuser: req_type; tdata: header fields and crc_match
//  m_*     | out | tdata: status and block state after the item
//
// A header steps through ST_HCHK, ST_HRD, ST_HOFF and ST_HFIN (a rejected one stops
// early), a verdict through ST_VCHK and, on a pass, ST_VRD; the shared multiplier and
// the registered bitmap reads set these steps. A verdict with a block pending then
// clears the packet bitmap before the next beat. After reset both bitmaps are cleared.
// A result waiting in the output register does not block acceptance of the next beat.
`default_nettype none
module block_packet_reassembly_tracker_unit #(
	parameter int unsigned MAX_BLOCKS  = 1024,
	parameter int unsigned MAX_PACKETS = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// block_total, block_number, packet_number, packet_total, payload_size,
	// block_crc, crc_match, zero fill
	input  wire logic [prt_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// status, write_offset, block_complete, block_index, block_length,
	// expected_crc, file_done
	output logic [prt_pkg::OUT_DATA_W-1:0]         m_tdata
);

	localparam int unsigned BW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned TW   = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned PW   = $clog2(MAX_PACKETS);
	localparam int unsigned PTW  = $clog2(MAX_PACKETS + 1);
	localparam int unsigned MAXD = (MAX_BLOCKS > MAX_PACKETS) ? MAX_BLOCKS : MAX_PACKETS;
	localparam int unsigned CW   = $clog2(MAXD + 1);

	prt_pkg::state_t state_q, state_d;

	logic                        req_q;
	logic [15:0]                 btot_q, bnum_q, pnum_q, ptot_q, psize_q;
	logic [prt_pkg::CRC_W-1:0]   crc_in_q;
	logic                        match_q;

	logic                        table_ready_q, table_ready_d;
	logic [TW-1:0]               total_q, total_d;
	logic [TW-1:0]               fin_q, fin_d;
	logic                        asm_q, asm_d;
	logic                        await_q, await_d;
	logic [BW-1:0]               cur_block_q, cur_block_d;
	logic [prt_pkg::CRC_W-1:0]   crc_q, crc_d;
	logic [PTW-1:0]              cur_ptot_q, cur_ptot_d;
	logic [prt_pkg::LEN_W-1:0]   len_q, len_d;
	logic [15:0]                 first_q, first_d;
	logic [PTW-1:0]              seen_q, seen_d;
	logic                        all_done_q, all_done_d;
	logic [CW-1:0]               cnt_q, cnt_d;

	logic                        out_valid_q;
	logic [prt_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                        out_load;
	prt_pkg::status_t            out_status;
	logic [prt_pkg::LEN_W-1:0]   out_offset;
	logic                        out_complete;

	logic                        out_free;
	logic                        accept;

	logic                        done_we, done_wd, done_re, done_rd;
	logic [BW-1:0]               done_waddr, done_raddr;
	logic                        pkt_we, pkt_re, pkt_rd;
	logic [PW-1:0]               pkt_waddr;

	logic [15:0]                 mul_a, mul_b;
	logic [prt_pkg::PROD_W-1:0]  prod_q;

	prt_pkg::status_t            chk_code, rd_code;
	logic                        btot_bad, is_last, trim_bad, over;
	logic [16:0]                 eff_total;
	logic [prt_pkg::LEN_W-1:0]   len_eff;
	logic [PTW-1:0]              seen_inc;
	logic [TW-1:0]               fin_inc;
	logic [31:0]                 blk_ext;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == prt_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	prt_bitmap #(.DEPTH(MAX_BLOCKS), .AW(BW)) u_done_map (
		.clk   (clk),
		.we    (done_we),
		.waddr (done_waddr),
		.wdata (done_wd),
		.re    (done_re),
		.raddr (done_raddr),
		.rdata (done_rd)
	);

	prt_bitmap #(.DEPTH(MAX_PACKETS), .AW(PW)) u_pkt_map (
		.clk   (clk),
		.we    (pkt_we),
		.waddr (pkt_waddr),
		.wdata (state_q == prt_pkg::ST_HFIN),
		.re    (pkt_re),
		.raddr (pnum_q[PW-1:0]),
		.rdata (pkt_rd)
	);

	assign mul_a = (state_q == prt_pkg::ST_HOFF) ? first_q : ptot_q;
	assign mul_b = (state_q == prt_pkg::ST_HOFF) ? pnum_q : psize_q;

	prt_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod_q)
	);

	always_comb begin
		btot_bad  = (btot_q == 16'd0) || ({1'b0, btot_q} > 17'(MAX_BLOCKS));
		eff_total = table_ready_q ? 17'(total_q) : {1'b0, btot_q};
		is_last   = (pnum_q == (ptot_q - 16'd1));
		priority if (!table_ready_q && btot_bad) begin
			chk_code = prt_pkg::STS_TOO_MANY;
		end else if (table_ready_q && ({1'b0, btot_q} != 17'(total_q))) begin
			chk_code = prt_pkg::STS_TOTAL_DIFF;
		end else if (await_q) begin
			chk_code = prt_pkg::STS_AWAITING;
		end else if (asm_q && ({1'b0, bnum_q} != 17'(cur_block_q))) begin
			chk_code = prt_pkg::STS_WRONG_BLOCK;
		end else if (({1'b0, bnum_q} >= eff_total) || (pnum_q >= ptot_q)
				|| ({1'b0, pnum_q} >= 17'(MAX_PACKETS))) begin
			chk_code = prt_pkg::STS_INDEX_RANGE;
		end else begin
			chk_code = prt_pkg::STS_ACCEPTED;
		end
		priority if (done_rd) begin
			rd_code = prt_pkg::STS_BLOCK_DONE;
		end else if (pkt_rd) begin
			rd_code = prt_pkg::STS_DUPLICATE;
		end else if (!asm_q && is_last) begin
			rd_code = prt_pkg::STS_LAST_FIRST;
		end else if (!asm_q && ({1'b0, ptot_q} > 17'(MAX_PACKETS))) begin
			rd_code = prt_pkg::STS_INDEX_RANGE;
		end else if (asm_q && ({1'b0, ptot_q} != 17'(cur_ptot_q))) begin
			rd_code = prt_pkg::STS_PTOT_DIFF;
		end else if (asm_q && (crc_in_q != crc_q)) begin
			rd_code = prt_pkg::STS_CRC_DIFF;
		end else begin
			rd_code = prt_pkg::STS_ACCEPTED;
		end
		trim_bad = is_last && (psize_q > first_q);
		len_eff  = is_last ? (len_q - 24'(first_q - psize_q)) : len_q;
		over     = (33'(prod_q) + 33'(psize_q)) > 33'(len_eff);
		seen_inc = seen_q + PTW'(1);
		fin_inc  = fin_q + TW'(1);
		blk_ext  = 32'(cur_block_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prt_pkg::ST_INIT: begin
				if (cnt_q == CW'(MAXD - 1)) begin
					state_d = prt_pkg::ST_IDLE;
				end
			end
			prt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = s_tuser ? prt_pkg::ST_VCHK : prt_pkg::ST_HCHK;
				end
			end
			prt_pkg::ST_HCHK: begin
				if (out_free) begin
					state_d = (chk_code == prt_pkg::STS_ACCEPTED) ? prt_pkg::ST_HRD
						: prt_pkg::ST_IDLE;
				end
			end
			prt_pkg::ST_HRD: begin
				state_d = (rd_code == prt_pkg::STS_ACCEPTED) ? prt_pkg::ST_HOFF
					: prt_pkg::ST_IDLE;
			end
			prt_pkg::ST_HOFF: begin
				state_d = prt_pkg::ST_HFIN;
			end
			prt_pkg::ST_HFIN: begin
				state_d = prt_pkg::ST_IDLE;
			end
			prt_pkg::ST_VCHK: begin
				if (out_free) begin
					priority if (!await_q) begin
						state_d = prt_pkg::ST_IDLE;
					end else if (match_q) begin
						state_d = prt_pkg::ST_VRD;
					end else begin
						state_d = prt_pkg::ST_CLR;
					end
				end
			end
			prt_pkg::ST_VRD: begin
				state_d = prt_pkg::ST_CLR;
			end
			prt_pkg::ST_CLR: begin
				if (cnt_q == CW'(MAX_PACKETS - 1)) begin
					state_d = prt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prt_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		table_ready_d = table_ready_q;
		total_d       = total_q;
		fin_d         = fin_q;
		asm_d         = asm_q;
		await_d       = await_q;
		cur_block_d   = cur_block_q;
		crc_d         = crc_q;
		cur_ptot_d    = cur_ptot_q;
		len_d         = len_q;
		first_d       = first_q;
		seen_d        = seen_q;
		all_done_d    = all_done_q;
		cnt_d         = '0;
		out_load      = 1'b0;
		out_status    = prt_pkg::STS_ACCEPTED;
		out_offset    = '0;
		out_complete  = 1'b0;
		done_we       = 1'b0;
		done_wd       = 1'b0;
		done_waddr    = cur_block_q;
		done_re       = 1'b0;
		done_raddr    = bnum_q[BW-1:0];
		pkt_we        = 1'b0;
		pkt_waddr     = pnum_q[PW-1:0];
		pkt_re        = 1'b0;
		unique case (state_q)
			prt_pkg::ST_INIT: begin
				cnt_d      = cnt_q + CW'(1);
				done_we    = (32'(cnt_q) < MAX_BLOCKS);
				done_waddr = cnt_q[BW-1:0];
				pkt_we     = (32'(cnt_q) < MAX_PACKETS);
				pkt_waddr  = cnt_q[PW-1:0];
			end
			prt_pkg::ST_HCHK: begin
				if (out_free) begin
					if (!table_ready_q && !btot_bad) begin
						table_ready_d = 1'b1;
						total_d       = TW'(btot_q);
					end
					if (chk_code == prt_pkg::STS_ACCEPTED) begin
						done_re = 1'b1;
						pkt_re  = 1'b1;
					end else begin
						out_load   = 1'b1;
						out_status = chk_code;
					end
				end
			end
			prt_pkg::ST_HRD: begin
				if (rd_code != prt_pkg::STS_ACCEPTED) begin
					out_load   = 1'b1;
					out_status = rd_code;
				end else if (!asm_q) begin
					asm_d       = 1'b1;
					cur_block_d = bnum_q[BW-1:0];
					crc_d       = crc_in_q;
					cur_ptot_d  = PTW'(ptot_q);
					len_d       = (|prod_q[prt_pkg::PROD_W-1:prt_pkg::LEN_W]) ? '1
						: prod_q[prt_pkg::LEN_W-1:0];
					first_d     = psize_q;
					seen_d      = '0;
				end
			end
			prt_pkg::ST_HFIN: begin
				out_load = 1'b1;
				if (trim_bad) begin
					out_status = prt_pkg::STS_OVERSIZE;
				end else begin
					len_d = len_eff;
					if (over) begin
						out_status = prt_pkg::STS_OVERFLOW;
					end else begin
						out_offset = prod_q[prt_pkg::LEN_W-1:0];
						pkt_we     = 1'b1;
						seen_d     = seen_inc;
						if (seen_inc >= cur_ptot_q) begin
							await_d      = 1'b1;
							out_complete = 1'b1;
						end
					end
				end
			end
			prt_pkg::ST_VCHK: begin
				if (out_free) begin
					priority if (!await_q) begin
						out_load   = 1'b1;
						out_status = prt_pkg::STS_NO_PENDING;
					end else if (match_q) begin
						done_re    = 1'b1;
						done_raddr = cur_block_q;
					end else begin
						out_load   = 1'b1;
						out_status = prt_pkg::STS_VERDICT_FAIL;
						asm_d      = 1'b0;
						await_d    = 1'b0;
						seen_d     = '0;
					end
				end
			end
			prt_pkg::ST_VRD: begin
				out_load   = 1'b1;
				out_status = prt_pkg::STS_VERDICT_PASS;
				asm_d      = 1'b0;
				await_d    = 1'b0;
				seen_d     = '0;
				if (!done_rd) begin
					done_we = 1'b1;
					done_wd = 1'b1;
					fin_d   = fin_inc;
				end
				if ((done_rd ? fin_q : fin_inc) >= total_q) begin
					all_done_d = 1'b1;
				end
			end
			prt_pkg::ST_CLR: begin
				cnt_d     = cnt_q + CW'(1);
				pkt_we    = 1'b1;
				pkt_waddr = cnt_q[PW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= prt_pkg::ST_INIT;
			table_ready_q <= 1'b0;
			total_q       <= '0;
			fin_q         <= '0;
			asm_q         <= 1'b0;
			await_q       <= 1'b0;
			cur_block_q   <= '0;
			crc_q         <= '0;
			cur_ptot_q    <= '0;
			len_q         <= '0;
			first_q       <= '0;
			seen_q        <= '0;
			all_done_q    <= 1'b0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			table_ready_q <= table_ready_d;
			total_q       <= total_d;
			fin_q         <= fin_d;
			asm_q         <= asm_d;
			await_q       <= await_d;
			cur_block_q   <= cur_block_d;
			crc_q         <= crc_d;
			cur_ptot_q    <= cur_ptot_d;
			len_q         <= len_d;
			first_q       <= first_d;
			seen_q        <= seen_d;
			all_done_q    <= all_done_d;
			cnt_q         <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= s_tuser;
			btot_q   <= s_tdata[15:0];
			bnum_q   <= s_tdata[31:16];
			pnum_q   <= s_tdata[47:32];
			ptot_q   <= s_tdata[63:48];
			psize_q  <= s_tdata[79:64];
			crc_in_q <= s_tdata[111:80];
			match_q  <= s_tdata[112];
		end
		if (out_load) begin
			out_data_q <= {all_done_d, crc_d, len_d, blk_ext[prt_pkg::INDEX_W-1:0],
				out_complete, out_offset, out_status};
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && (state_q == prt_pkg::ST_VRD)) begin
			assert (req_q) else $error("verdict finished for a header beat");
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) await_q |-> asm_q)
		else $error("verdict pending without a block being assembled");

	assert property (@(posedge clk) disable iff (!arst_n) all_done_q |-> table_ready_q)
		else $error("file done before the block total was latched");

	assert property (@(posedge clk) disable iff (!arst_n) fin_q <= total_q)
		else $error("more blocks finished than the file holds");

	assert property (@(posedge clk) disable iff (!arst_n) seen_q <= cur_ptot_q)
		else $error("more packets seen than the block holds");

	assert property (@(posedge clk) disable iff (!arst_n)
			(out_valid_q && !m_tready) |-> !out_load)
		else $error("result overwritten while still waiting");

endmodule
`default_nettype wire

// File: rtl/core/prt_bitmap.sv
// One-bit-wide bitmap memory with one write port and one registered read port.
`default_nettype none
module prt_bitmap #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic          wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic               rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/prt_mul.sv
// Shared 16 by 16 multiplier with a registered product.
`default_nettype none
module prt_mul (
	input  wire logic                         clk,
	input  wire logic [prt_pkg::SIZE_W-1:0]   a,
	input  wire logic [prt_pkg::SIZE_W-1:0]   b,
	output logic      [prt_pkg::PROD_W-1:0]   p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule
`default_nettype wire

// File: bench/tb_block_packet_reassembly_tracker_unit.sv
// Self-checking testbench for the packet reassembly tracker: directed and random header and verdict beats.
`timescale 1ns / 100ps
module tb_block_packet_reassembly_tracker_unit;

	typedef struct {
		bit        is_verdict;
		bit [15:0] btot;
		bit [15:0] bnum;
		bit [15:0] pnum;
		bit [15:0] ptot;
		bit [15:0] psize;
		bit [31:0] crc;
		bit        crc_ok;
	} header_t;

	typedef struct {
		prt_pkg::status_t sts;
		bit [23:0] offset;
		bit        complete;
		bit [9:0]  bidx;
		bit [23:0] blen;
		bit [31:0] ecrc;
		bit        fdone;
	} tracker_result_t;

	class reassembly_scoreboard;
		bit              table_ready;
		int unsigned     total_blocks;
		int unsigned     blocks_finished;
		bit              block_done[1024];
		bit              assembling;
		bit              awaiting;
		int unsigned     cur_block;
		bit [31:0]       cur_crc;
		int unsigned     cur_ptot;
		int unsigned     cur_len;
		int unsigned     first_size;
		bit              seen[256];
		int unsigned     seen_count;
		bit              all_done;
		tracker_result_t pending_results[$];
		int              errors;
		int              checked;
		int              accepted_payloads;
		int              passes;

		function void drop_block();
			foreach (seen[i]) seen[i] = 0;
			seen_count = 0;
			assembling = 0;
			awaiting = 0;
		endfunction

		function prt_pkg::status_t apply_header(header_t h, output bit [23:0] off,
				output bit cmpl);
			int unsigned bnum, pnum, ptot, psize, o;
			bnum = h.bnum;
			pnum = h.pnum;
			ptot = h.ptot;
			psize = h.psize;
			off = 0;
			cmpl = 0;
			if (!table_ready) begin
				if (h.btot == 0 || h.btot > 1024)
					return prt_pkg::STS_TOO_MANY;
				table_ready = 1;
				total_blocks = h.btot;
			end else if (h.btot != total_blocks)
				return prt_pkg::STS_TOTAL_DIFF;
			if (awaiting)
				return prt_pkg::STS_AWAITING;
			if (assembling && bnum != cur_block)
				return prt_pkg::STS_WRONG_BLOCK;
			if (bnum >= total_blocks || pnum >= ptot || pnum >= 256)
				return prt_pkg::STS_INDEX_RANGE;
			if (block_done[bnum])
				return prt_pkg::STS_BLOCK_DONE;
			if (seen[pnum])
				return prt_pkg::STS_DUPLICATE;
			if (!assembling) begin
				if (pnum == ptot - 1)
					return prt_pkg::STS_LAST_FIRST;
				if (ptot > 256)
					return prt_pkg::STS_INDEX_RANGE;
				assembling = 1;
				cur_block = bnum;
				cur_crc = h.crc;
				cur_ptot = ptot;
				cur_len = ptot * psize;
				first_size = psize;
				foreach (seen[i]) seen[i] = 0;
				seen_count = 0;
			end else begin
				if (ptot != cur_ptot)
					return prt_pkg::STS_PTOT_DIFF;
				if (h.crc != cur_crc)
					return prt_pkg::STS_CRC_DIFF;
			end
			if (pnum == ptot - 1) begin
				if (psize > first_size)
					return prt_pkg::STS_OVERSIZE;
				cur_len = cur_len - (first_size - psize);
			end
			o = first_size * pnum;
			if (o + psize > cur_len)
				return prt_pkg::STS_OVERFLOW;
			off = 24'(o);
			seen[pnum] = 1;
			seen_count++;
			if (seen_count >= cur_ptot) begin
				awaiting = 1;
				cmpl = 1;
			end
			return prt_pkg::STS_ACCEPTED;
		endfunction

		function void note_beat(header_t h);
			tracker_result_t r;
			r.offset = 0;
			r.complete = 0;
			if (h.is_verdict) begin
				if (!awaiting)
					r.sts = prt_pkg::STS_NO_PENDING;
				else begin
					if (h.crc_ok) begin
						if (!block_done[cur_block]) begin
							block_done[cur_block] = 1;
							blocks_finished++;
						end
						if (blocks_finished >= total_blocks)
							all_done = 1;
						r.sts = prt_pkg::STS_VERDICT_PASS;
						passes++;
					end else
						r.sts = prt_pkg::STS_VERDICT_FAIL;
					drop_block();
				end
			end else
				r.sts = apply_header(h, r.offset, r.complete);
			if (r.sts == prt_pkg::STS_ACCEPTED)
				accepted_payloads++;
			r.bidx = cur_block[9:0];
			r.blen = cur_len[23:0];
			r.ecrc = cur_crc;
			r.fdone = all_done;
			pending_results.push_back(r);
		endfunction

		function void check_result(bit [prt_pkg::OUT_DATA_W-1:0] d);
			tracker_result_t e;
			checked++;
			if (pending_results.size() == 0) begin
				$display("%0t: result beat %h arrived with nothing expected", $time, d);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (d[3:0] != e.sts) begin
				$display("%0t: status expected %0d actual %0d", $time, e.sts, d[3:0]);
				errors++;
			end
			if (d[27:4] != e.offset) begin
				$display("%0t: write_offset expected %0d actual %0d", $time, e.offset, d[27:4]);
				errors++;
			end
			if (d[28] != e.complete) begin
				$display("%0t: block_complete expected %0d actual %0d", $time, e.complete, d[28]);
				errors++;
			end
			if (d[38:29] != e.bidx) begin
				$display("%0t: block_index expected %0d actual %0d", $time, e.bidx, d[38:29]);
				errors++;
			end
			if (d[62:39] != e.blen) begin
				$display("%0t: block_length expected %0d actual %0d", $time, e.blen, d[62:39]);
				errors++;
			end
			if (d[94:63] != e.ecrc) begin
				$display("%0t: expected_crc expected %h actual %h", $time, e.ecrc, d[94:63]);
				errors++;
			end
			if (d[95] != e.fdone) begin
				$display("%0t: file_done expected %0d actual %0d", $time, e.fdone, d[95]);
				errors++;
			end
		endfunction
	endclass

	localparam int unsigned FILE_BLOCKS = 6;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [prt_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [prt_pkg::OUT_DATA_W-1:0] m_tdata;

	reassembly_scoreboard sb = new();
	int unsigned sender_idle;
	int unsigned receiver_idle;
	int unsigned pass_pct;

	block_packet_reassembly_tracker_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= receiver_idle);
	end

	task automatic send_beat(header_t h);
		if (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= h.is_verdict;
		s_tdata <= {7'b0, h.crc_ok, h.crc, h.psize, h.ptot, h.pnum, h.bnum, h.btot};
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_beat(h);
	endtask

	task automatic send_header(int unsigned btot, int unsigned bnum, int unsigned pnum,
			int unsigned ptot, int unsigned psize, bit [31:0] crc);
		header_t h;
		h.is_verdict = 0;
		h.btot = 16'(btot);
		h.bnum = 16'(bnum);
		h.pnum = 16'(pnum);
		h.ptot = 16'(ptot);
		h.psize = 16'(psize);
		h.crc = crc;
		h.crc_ok = 1'($urandom_range(1));
		send_beat(h);
	endtask

	task automatic send_verdict(bit ok);
		header_t h;
		h.is_verdict = 1;
		h.btot = 16'($urandom);
		h.bnum = 16'($urandom);
		h.pnum = 16'($urandom);
		h.ptot = 16'($urandom);
		h.psize = 16'($urandom);
		h.crc = $urandom;
		h.crc_ok = ok;
		send_beat(h);
	endtask

	task automatic random_beat();
		int unsigned pick, ptot, psize, pnum, bnum;
		pick = $urandom_range(99);
		if (sb.awaiting) begin
			if (pick < 8)
				send_header(FILE_BLOCKS, sb.cur_block, 0, sb.cur_ptot, 1, sb.cur_crc);
			else
				send_verdict($urandom_range(99) < pass_pct);
		end else if (sb.assembling) begin
			ptot = sb.cur_ptot;
			do pnum = $urandom_range(ptot - 1); while (sb.seen[pnum] && pick >= 4);
			psize = (pnum == ptot - 1) ? $urandom_range(sb.first_size) : sb.first_size;
			if (pick < 4)
				send_header(FILE_BLOCKS, sb.cur_block, pnum, ptot, psize, sb.cur_crc);
			else if (pick < 6)
				send_header($urandom, sb.cur_block, pnum, ptot, psize, sb.cur_crc);
			else if (pick < 8)
				send_header(FILE_BLOCKS, $urandom_range(FILE_BLOCKS - 1), pnum, ptot, psize,
					sb.cur_crc);
			else if (pick < 10)
				send_header(FILE_BLOCKS, sb.cur_block, ptot + $urandom_range(3), ptot, psize,
					sb.cur_crc);
			else if (pick < 12)
				send_header(FILE_BLOCKS, sb.cur_block, pnum, ptot + 1, psize, sb.cur_crc);
			else if (pick < 14)
				send_header(FILE_BLOCKS, sb.cur_block, pnum, ptot, psize, $urandom);
			else if (pick < 16)
				send_header(FILE_BLOCKS, sb.cur_block, pnum, ptot,
					psize + $urandom_range(1, 2 * sb.first_size + 1), sb.cur_crc);
			else if (pick < 18)
				send_verdict(1'($urandom_range(1)));
			else if (pick < 19)
				send_header($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else
				send_header(FILE_BLOCKS, sb.cur_block, pnum, ptot, psize, sb.cur_crc);
		end else begin
			bnum = $urandom_range(FILE_BLOCKS - 1);
			if ($urandom_range(199) == 0)
				ptot = 256;
			else
				ptot = $urandom_range(2, 8);
			psize = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1500);
			pnum = $urandom_range(ptot - 2);
			if (pick < 6)
				send_verdict(1'($urandom_range(1)));
			else if (pick < 10)
				send_header(FILE_BLOCKS, bnum, ptot - 1, ptot, psize, $urandom);
			else if (pick < 13)
				send_header(FILE_BLOCKS, bnum, pnum, $urandom_range(257, 65535), psize, $urandom);
			else if (pick < 16)
				send_header(FILE_BLOCKS, $urandom_range(FILE_BLOCKS, 65535), pnum, ptot, psize,
					$urandom);
			else if (pick < 18)
				send_header($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else
				send_header(FILE_BLOCKS, bnum, pnum, ptot, psize, $urandom);
		end
	endtask

	initial begin
		int unsigned n, wait_cycles;
		arst_n = 0;
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = '0;
		m_tready = 0;
		sender_idle = 0;
		receiver_idle = 0;
		pass_pct = 12;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_header(0, 0, 0, 2, 10, 0);
		send_header(1025, 0, 0, 2, 10, 0);
		send_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_verdict(1);
		send_header(FILE_BLOCKS, 5, 0, 2, 16'hFFFF, 32'hFFFF_FFFF);
		send_header(FILE_BLOCKS, 5, 0, 2, 16'hFFFF, 32'hFFFF_FFFF);
		send_header(FILE_BLOCKS + 1, 5, 1, 2, 16'hFFFF, 32'hFFFF_FFFF);
		send_header(FILE_BLOCKS, 3, 1, 2, 16'hFFFF, 32'hFFFF_FFFF);
		send_header(FILE_BLOCKS, 5, 2, 2, 16'hFFFF, 32'hFFFF_FFFF);
		send_header(FILE_BLOCKS, 5, 1, 3, 16'hFFFF, 32'hFFFF_FFFF);
		send_header(FILE_BLOCKS, 5, 1, 2, 16'hFFFF, 32'h0);
		send_header(FILE_BLOCKS, 5, 1, 2, 16'hFFFF, 32'hFFFF_FFFF);
		send_header(FILE_BLOCKS, 5, 0, 2, 1, 32'hFFFF_FFFF);
		send_verdict(0);
		send_header(FILE_BLOCKS, 5, 1, 2, 100, 32'h1234_5678);
		send_header(FILE_BLOCKS, FILE_BLOCKS, 0, 2, 100, 32'h1234_5678);
		send_header(FILE_BLOCKS, 0, 0, 2, 0, 32'h0);
		send_header(FILE_BLOCKS, 0, 1, 2, 0, 32'h0);
		send_verdict(1);
		send_header(FILE_BLOCKS, 0, 0, 2, 0, 32'h0);
		send_header(FILE_BLOCKS, 4, 0, 3, 40, 32'hA5A5_A5A5);
		send_header(FILE_BLOCKS, 4, 2, 3, 41, 32'hA5A5_A5A5);

		for (n = 0; n < 1530; n++) begin
			if (n == 510) begin
				sender_idle = 71;
				receiver_idle = 16;
			end else if (n == 1020) begin
				sender_idle = 0;
				receiver_idle = 0;
			end else if (n == 0) begin
				sender_idle = 16;
				receiver_idle = 71;
			end
			if (n >= 1250)
				pass_pct = 100;
			random_beat();
		end
		s_tvalid <= 0;

		wait_cycles = 0;
		while (sb.pending_results.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (300) @(posedge clk);
		$display("Run checked %0d results: %0d payload writes accepted, %0d blocks passed,",
			sb.checked, sb.accepted_payloads, sb.passes);
		$display("file complete flag %0d after %0d of %0d blocks verified.",
			sb.all_done, sb.blocks_finished, sb.total_blocks);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
rtl/core/prt_pkg.sv
rtl/core/prt_bitmap.sv
rtl/core/prt_mul.sv
rtl/core/block_packet_reassembly_tracker_unit.sv
bench/tb_block_packet_reassembly_tracker_unit.sv
